@@ hdl/pgn3d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perlin gradient noise package
// Request codes and the fixed field widths shared by the noise pipeline.
// ----------------------------------------------------------------------------
package pgn3d_pkg;

  typedef enum logic [1:0] {
    OP_EVAL    = 2'd0,
    OP_WR_PERM = 2'd1,
    OP_WR_GRAD = 2'd2
  } op_e;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned GRAD_W  = 16;
  localparam int unsigned TIDX_W  = 8;
  localparam int unsigned NOISE_W = 16;

  // Fraction and s-curve widths (Q16).
  localparam int unsigned FRAC_W  = 18;
  localparam int unsigned SC_W    = 20;
  localparam int unsigned CURVE_W = 19;

  // Lattice bias of 4096 units in Q16.
  localparam logic signed [COORD_W:0] LATTICE_BIAS = 33'sh0_1000_0000;
  localparam int unsigned BIAS_UNITS = 28672;

  // Interpolation widths per level.
  localparam int unsigned DOT_W = 22;
  localparam int unsigned XL_W  = 27;
  localparam int unsigned YL_W  = 31;
  localparam int unsigned ZL_W  = 35;

  localparam logic signed [SC_W-1:0] SC_MAX = 20'sd327680;

endpackage

@@ hdl/pgn3d_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic table RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module pgn3d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/perlin_gradient_noise_3d.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perlin gradient noise, 3-D
// Evaluates fixed-point gradient noise at a point and loads its tables.
// ----------------------------------------------------------------------------
// The input channel carries one request per accepted cycle: an evaluate
// request with a Q16.16 point, or a write of one permutation or gradient
// entry. Each evaluate request yields one Q2.14 noise value on the output
// channel; writes and the unused code yield nothing.
// A new request can be accepted every cycle while in_stall_o is low. The
// pipeline holds fourteen stages plus the output register; the depth is
// set by the chain of dependent table reads (permutation, permutation,
// gradient) and the three interpolation levels, each a multiply stage
// followed by a round-and-add stage.
// Table writes travel the same pipeline and update each table copy at the
// stage where that copy is read, so requests see writes in order.
// When the receiver stalls, the result is held and empty stages keep
// filling; in_stall_o rises only when every stage is occupied.
// Reset empties the pipeline. The tables are not cleared and must be loaded
// before an evaluate request uses them.
// ----------------------------------------------------------------------------
module perlin_gradient_noise_3d #(
  parameter int TABLE_SIZE = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           op_i,
  input  logic signed [pgn3d_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [pgn3d_pkg::COORD_W-1:0] coord_y_i,
  input  logic signed [pgn3d_pkg::COORD_W-1:0] coord_z_i,
  input  logic [pgn3d_pkg::TIDX_W-1:0]         table_index_i,
  input  logic [pgn3d_pkg::TIDX_W-1:0]         perm_value_i,
  input  logic signed [pgn3d_pkg::GRAD_W-1:0]  grad_x_i,
  input  logic signed [pgn3d_pkg::GRAD_W-1:0]  grad_y_i,
  input  logic signed [pgn3d_pkg::GRAD_W-1:0]  grad_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [pgn3d_pkg::NOISE_W-1:0] noise_value_o
);

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int IPP_W  = 17;
  localparam int SH     = IPP_W + IDX_W;
  localparam int RC_W   = 19;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SH) + longint'(TABLE_SIZE) - 1) / longint'(TABLE_SIZE);
  localparam logic [RC_W-1:0] RECIP = RC_W'(RECIP_L);
  localparam int OFF_I = ((pgn3d_pkg::BIAS_UNITS + TABLE_SIZE - 1) / TABLE_SIZE) * TABLE_SIZE;
  localparam logic [IPP_W-1:0] OFF   = IPP_W'(OFF_I);
  localparam logic [IPP_W-1:0] N_IPP = IPP_W'(TABLE_SIZE);
  localparam logic [IDX_W:0]   N_EXT = (IDX_W + 1)'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] N_TOP = IDX_W'(TABLE_SIZE - 1);
  localparam int GW     = 3 * pgn3d_pkg::GRAD_W;
  localparam int NS     = 14;
  localparam int FW     = pgn3d_pkg::FRAC_W;
  localparam int SW     = pgn3d_pkg::SC_W;
  localparam int DW     = pgn3d_pkg::DOT_W;
  localparam int XW     = pgn3d_pkg::XL_W;
  localparam int YW     = pgn3d_pkg::YL_W;
  localparam int ZW     = pgn3d_pkg::ZL_W;
  localparam int PW     = FW + pgn3d_pkg::GRAD_W;

  function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [IDX_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= N_EXT) begin
      sum = sum - N_EXT;
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic tidx_ok(input logic [pgn3d_pkg::TIDX_W-1:0] idx);
    return (32'(idx) < 32'(TABLE_SIZE));
  endfunction

  // Stage control.
  logic [NS:1] v_q;
  logic [NS:1] ld;
  logic        ld_out;
  logic        out_valid_q;
  logic signed [pgn3d_pkg::NOISE_W-1:0] noise_q;

  always_comb begin
    ld_out = !out_valid_q || !out_stall_i;
    ld[NS] = !v_q[NS] || ld_out;
    for (int k = NS - 1; k >= 1; k--) begin
      ld[k] = !v_q[k] || ld[k+1];
    end
  end

  assign in_stall_o    = !ld[1];
  assign out_valid_o   = out_valid_q;
  assign noise_value_o = noise_q;

  // Stage 1: bias, truncate and split each coordinate; a permutation write routes its value through the x index.
  logic signed [pgn3d_pkg::COORD_W-1:0] coord [3];
  logic [IPP_W-1:0]     s1_ipp_d [3];
  logic signed [FW-1:0] s1_r0_d  [3];
  logic [IPP_W-1:0]     s1_ipp_q [3];
  logic signed [FW-1:0] s1_r0_q  [3];
  logic [1:0]           s1_op_q;
  logic [pgn3d_pkg::TIDX_W-1:0] s1_tidx_q;
  logic [GW-1:0]        s1_grad_q;

  assign coord[0] = coord_x_i;
  assign coord[1] = coord_y_i;
  assign coord[2] = coord_z_i;

  always_comb begin
    logic signed [pgn3d_pkg::COORD_W:0] t;
    logic [pgn3d_pkg::COORD_W:0] mag;
    for (int a = 0; a < 3; a++) begin
      t   = (pgn3d_pkg::COORD_W + 1)'(coord[a]) + pgn3d_pkg::LATTICE_BIAS;
      mag = t[pgn3d_pkg::COORD_W] ? 33'(-t) : 33'(t);
      if (t[pgn3d_pkg::COORD_W]) begin
        s1_ipp_d[a] = OFF - mag[32:16];
        s1_r0_d[a]  = -$signed({2'b00, mag[15:0]});
      end else begin
        s1_ipp_d[a] = OFF + mag[32:16];
        s1_r0_d[a]  = $signed({2'b00, mag[15:0]});
      end
    end
    if (op_i == pgn3d_pkg::OP_WR_PERM) begin
      s1_ipp_d[0] = IPP_W'(perm_value_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      s1_ipp_q  <= s1_ipp_d;
      s1_r0_q   <= s1_r0_d;
      s1_op_q   <= op_i;
      s1_tidx_q <= table_index_i;
      s1_grad_q <= {grad_x_i, grad_y_i, grad_z_i};
    end
  end

  // Stage 2: reciprocal quotient, square of the fraction, curve weight.
  logic [IPP_W-1:0]       s2_ipp_q [3];
  logic [IPP_W-1:0]       s2_q_q   [3];
  logic [31:0]            s2_rr_q  [3];
  logic [pgn3d_pkg::CURVE_W-1:0] s2_w_q [3];
  logic signed [FW-1:0]   s2_r0_q  [3];
  logic [1:0]             s2_op_q;
  logic [pgn3d_pkg::TIDX_W-1:0] s2_tidx_q;
  logic [GW-1:0]          s2_grad_q;

  always_ff @(posedge clk_i) begin
    logic [IPP_W+RC_W-1:0] qp;
    logic signed [2*FW-1:0] sq;
    logic signed [19:0] wt;
    if (ld[2]) begin
      for (int a = 0; a < 3; a++) begin
        qp           = s1_ipp_q[a] * RECIP;
        sq           = s1_r0_q[a] * s1_r0_q[a];
        wt           = 20'sd196608 - $signed({s1_r0_q[a][FW-1], s1_r0_q[a], 1'b0});
        s2_q_q[a]   <= IPP_W'(qp >> SH);
        s2_rr_q[a]  <= sq[31:0];
        s2_w_q[a]   <= wt[pgn3d_pkg::CURVE_W-1:0];
      end
      s2_ipp_q  <= s1_ipp_q;
      s2_r0_q   <= s1_r0_q;
      s2_op_q   <= s1_op_q;
      s2_tidx_q <= s1_tidx_q;
      s2_grad_q <= s1_grad_q;
    end
  end

  // Stage 3: remainder and partial curve products.
  logic [IDX_W-1:0]     s3_i0_q [3];
  logic [34:0]          s3_ph_q [3];
  logic [34:0]          s3_pl_q [3];
  logic signed [FW-1:0] s3_r0_q [3];
  logic [1:0]           s3_op_q;
  logic [pgn3d_pkg::TIDX_W-1:0] s3_tidx_q;
  logic [GW-1:0]        s3_grad_q;

  always_ff @(posedge clk_i) begin
    logic [IPP_W-1:0] qn;
    logic [IPP_W-1:0] rem;
    if (ld[3]) begin
      for (int a = 0; a < 3; a++) begin
        qn          = s2_q_q[a] * N_IPP;
        rem         = s2_ipp_q[a] - qn;
        s3_i0_q[a] <= rem[IDX_W-1:0];
        s3_ph_q[a] <= 35'(s2_rr_q[a][31:16]) * 35'(s2_w_q[a]);
        s3_pl_q[a] <= 35'(s2_rr_q[a][15:0]) * 35'(s2_w_q[a]);
      end
      s3_r0_q   <= s2_r0_q;
      s3_op_q   <= s2_op_q;
      s3_tidx_q <= s2_tidx_q;
      s3_grad_q <= s2_grad_q;
    end
  end

  // Stage 4: neighbor index and rounded s-curve.
  logic [IDX_W-1:0]     s4_i0_q [3];
  logic [IDX_W-1:0]     s4_i1_q [3];
  logic signed [SW-1:0] s4_s_q  [3];
  logic signed [FW-1:0] s4_r0_q [3];
  logic [1:0]           s4_op_q;
  logic [pgn3d_pkg::TIDX_W-1:0] s4_tidx_q;
  logic [GW-1:0]        s4_grad_q;

  always_ff @(posedge clk_i) begin
    logic [51:0] p;
    if (ld[4]) begin
      for (int a = 0; a < 3; a++) begin
        p           = {1'b0, s3_ph_q[a], 16'h0000} + 52'(s3_pl_q[a]) + 52'h0_0000_8000_0000;
        s4_s_q[a]  <= $signed(p[51:32]);
        s4_i0_q[a] <= s3_i0_q[a];
        s4_i1_q[a] <= (s3_i0_q[a] == N_TOP) ? '0 : s3_i0_q[a] + 1'b1;
      end
      s4_r0_q   <= s3_r0_q;
      s4_op_q   <= s3_op_q;
      s4_tidx_q <= s3_tidx_q;
      s4_grad_q <= s3_grad_q;
    end
  end

  // First permutation lookup; copies written where they are read.
  logic [IDX_W-1:0] perm_a_rd [2];
  logic             perm_a_we;

  assign perm_a_we = ld[5] && v_q[4] && (s4_op_q == pgn3d_pkg::OP_WR_PERM) &&
                     tidx_ok(s4_tidx_q);

  for (genvar g = 0; g < 2; g++) begin : g_perm_a
    pgn3d_ram #(
      .WIDTH(IDX_W),
      .DEPTH(TABLE_SIZE)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (perm_a_we),
      .waddr_i(IDX_W'(s4_tidx_q)),
      .wdata_i(s4_i0_q[0]),
      .re_i   (ld[5]),
      .raddr_i((g == 0) ? s4_i0_q[0] : s4_i1_q[0]),
      .rdata_o(perm_a_rd[g])
    );
  end

  // Stage 5: second permutation lookup.
  logic [IDX_W-1:0]     s5_by_q [2];
  logic [IDX_W-1:0]     s5_bz_q [2];
  logic signed [SW-1:0] s5_s_q  [3];
  logic signed [FW-1:0] s5_r0_q [3];
  logic [1:0]           s5_op_q;
  logic [pgn3d_pkg::TIDX_W-1:0] s5_tidx_q;
  logic [GW-1:0]        s5_grad_q;
  logic [IDX_W-1:0]     s5_pd_q;

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      s5_by_q[0] <= s4_i0_q[1];
      s5_by_q[1] <= s4_i1_q[1];
      s5_bz_q[0] <= s4_i0_q[2];
      s5_bz_q[1] <= s4_i1_q[2];
      s5_s_q     <= s4_s_q;
      s5_r0_q    <= s4_r0_q;
      s5_op_q    <= s4_op_q;
      s5_tidx_q  <= s4_tidx_q;
      s5_grad_q  <= s4_grad_q;
      s5_pd_q    <= s4_i0_q[0];
    end
  end

  logic [IDX_W-1:0] perm_b_addr [4];
  logic [IDX_W-1:0] perm_b_rd   [4];
  logic             perm_b_we;

  assign perm_b_we = ld[6] && v_q[5] && (s5_op_q == pgn3d_pkg::OP_WR_PERM) &&
                     tidx_ok(s5_tidx_q);

  for (genvar g = 0; g < 4; g++) begin : g_perm_b
    assign perm_b_addr[g] = mod_add(perm_a_rd[g%2], s5_by_q[g/2]);

    pgn3d_ram #(
      .WIDTH(IDX_W),
      .DEPTH(TABLE_SIZE)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (perm_b_we),
      .waddr_i(IDX_W'(s5_tidx_q)),
      .wdata_i(s5_pd_q),
      .re_i   (ld[6]),
      .raddr_i(perm_b_addr[g]),
      .rdata_o(perm_b_rd[g])
    );
  end

  // Stage 6: gradient lookup for the eight corners.
  logic [IDX_W-1:0]     s6_bz_q [2];
  logic signed [SW-1:0] s6_s_q  [3];
  logic signed [FW-1:0] s6_r0_q [3];
  logic [1:0]           s6_op_q;
  logic [pgn3d_pkg::TIDX_W-1:0] s6_tidx_q;
  logic [GW-1:0]        s6_grad_q;

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      s6_bz_q   <= s5_bz_q;
      s6_s_q    <= s5_s_q;
      s6_r0_q   <= s5_r0_q;
      s6_op_q   <= s5_op_q;
      s6_tidx_q <= s5_tidx_q;
      s6_grad_q <= s5_grad_q;
    end
  end

  logic [IDX_W-1:0] grad_addr [8];
  logic [GW-1:0]    grad_rd   [8];
  logic             grad_we;

  assign grad_we = ld[7] && v_q[6] && (s6_op_q == pgn3d_pkg::OP_WR_GRAD) &&
                   tidx_ok(s6_tidx_q);

  for (genvar c = 0; c < 8; c++) begin : g_grad
    assign grad_addr[c] = mod_add(perm_b_rd[c%4], s6_bz_q[c/4]);

    pgn3d_ram #(
      .WIDTH(GW),
      .DEPTH(TABLE_SIZE)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (grad_we),
      .waddr_i(IDX_W'(s6_tidx_q)),
      .wdata_i(s6_grad_q),
      .re_i   (ld[7]),
      .raddr_i(grad_addr[c]),
      .rdata_o(grad_rd[c])
    );
  end

  // Stage 7: gradients are in the RAM output registers.
  logic signed [SW-1:0] s7_s_q  [3];
  logic signed [FW-1:0] s7_r0_q [3];
  logic                 s7_eval_q;

  always_ff @(posedge clk_i) begin
    if (ld[7]) begin
      s7_s_q    <= s6_s_q;
      s7_r0_q   <= s6_r0_q;
      s7_eval_q <= (s6_op_q == pgn3d_pkg::OP_EVAL);
    end
  end

  // Stage 8: corner offset times gradient, per axis.
  logic signed [PW-1:0] s8_prod_q [8][3];
  logic signed [SW-1:0] s8_s_q    [3];

  always_ff @(posedge clk_i) begin
    logic signed [FW-1:0] rs;
    logic signed [pgn3d_pkg::GRAD_W-1:0] gc;
    if (ld[8]) begin
      for (int c = 0; c < 8; c++) begin
        for (int a = 0; a < 3; a++) begin
          rs = c[a] ? s7_r0_q[a] - 18'sd65536 : s7_r0_q[a];
          gc = $signed(grad_rd[c][(2-a)*pgn3d_pkg::GRAD_W +: pgn3d_pkg::GRAD_W]);
          s8_prod_q[c][a] <= rs * gc;
        end
      end
      s8_s_q <= s7_s_q;
    end
  end

  // Stage 9: dot products rounded to Q16.
  logic signed [DW-1:0] s9_dot_q [8];
  logic signed [SW-1:0] s9_s_q   [3];

  always_ff @(posedge clk_i) begin
    logic signed [PW+1:0] sum;
    if (ld[9]) begin
      for (int c = 0; c < 8; c++) begin
        sum = (PW + 2)'(s8_prod_q[c][0]) + (PW + 2)'(s8_prod_q[c][1]) +
              (PW + 2)'(s8_prod_q[c][2]) + (PW + 2)'(15'sd8192);
        s9_dot_q[c] <= sum[PW+1:14];
      end
      s9_s_q <= s8_s_q;
    end
  end

  // Stages 10 and 11: interpolation along x.
  logic signed [SW+DW:0]  s10_prod_q [4];
  logic signed [DW-1:0]   s10_u_q    [4];
  logic signed [SW-1:0]   s10_s_q    [3];

  always_ff @(posedge clk_i) begin
    logic signed [DW:0] df;
    if (ld[10]) begin
      for (int k = 0; k < 4; k++) begin
        df            = (DW + 1)'(s9_dot_q[2*k+1]) - (DW + 1)'(s9_dot_q[2*k]);
        s10_prod_q[k] <= s9_s_q[0] * df;
        s10_u_q[k]    <= s9_dot_q[2*k];
      end
      s10_s_q <= s9_s_q;
    end
  end

  logic signed [XW-1:0] s11_xl_q [4];
  logic signed [SW-1:0] s11_s_q  [3];

  always_ff @(posedge clk_i) begin
    logic signed [SW+DW:0] rp;
    if (ld[11]) begin
      for (int k = 0; k < 4; k++) begin
        rp           = s10_prod_q[k] + (SW + DW + 1)'(17'sd32768);
        s11_xl_q[k] <= XW'(s10_u_q[k]) + XW'(rp[SW+DW:16]);
      end
      s11_s_q <= s10_s_q;
    end
  end

  // Stages 12 and 13: interpolation along y.
  logic signed [SW+XW:0] s12_prod_q [2];
  logic signed [XW-1:0]  s12_u_q    [2];
  logic signed [SW-1:0]  s12_s_q    [3];

  always_ff @(posedge clk_i) begin
    logic signed [XW:0] df;
    if (ld[12]) begin
      for (int k = 0; k < 2; k++) begin
        df            = (XW + 1)'(s11_xl_q[2*k+1]) - (XW + 1)'(s11_xl_q[2*k]);
        s12_prod_q[k] <= s11_s_q[1] * df;
        s12_u_q[k]    <= s11_xl_q[2*k];
      end
      s12_s_q <= s11_s_q;
    end
  end

  logic signed [YW-1:0] s13_yl_q [2];
  logic signed [SW-1:0] s13_sz_q;

  always_ff @(posedge clk_i) begin
    logic signed [SW+XW:0] rp;
    if (ld[13]) begin
      for (int k = 0; k < 2; k++) begin
        rp           = s12_prod_q[k] + (SW + XW + 1)'(17'sd32768);
        s13_yl_q[k] <= YW'(s12_u_q[k]) + YW'(rp[SW+XW:16]);
      end
      s13_sz_q <= s12_s_q[2];
    end
  end

  // Stage 14: interpolation product along z.
  logic signed [SW+YW:0] s14_prod_q;
  logic signed [YW-1:0]  s14_u_q;

  always_ff @(posedge clk_i) begin
    logic signed [YW:0] df;
    if (ld[14]) begin
      df         = (YW + 1)'(s13_yl_q[1]) - (YW + 1)'(s13_yl_q[0]);
      s14_prod_q <= s13_sz_q * df;
      s14_u_q    <= s13_yl_q[0];
    end
  end

  // Output: finish the z interpolation, round to Q14 and saturate.
  always_ff @(posedge clk_i) begin
    logic signed [SW+YW:0] rp;
    logic signed [ZW-1:0]  zl;
    logic signed [ZW-1:0]  nr;
    if (ld_out) begin
      rp = s14_prod_q + (SW + YW + 1)'(17'sd32768);
      zl = ZW'(s14_u_q) + ZW'(rp[SW+YW:16]);
      nr = (zl + ZW'(3'sd2)) >>> 2;
      if (nr > ZW'(17'sd32767)) begin
        noise_q <= 16'sh7fff;
      end else if (nr < ZW'(-17'sd32768)) begin
        noise_q <= 16'sh8000;
      end else begin
        noise_q <= nr[15:0];
      end
    end
  end

  // Occupancy; writes and the unused code leave the pipeline after stage 7.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NS; k++) begin
        if (ld[k]) begin
          v_q[k] <= (k == 8) ? (v_q[k-1] && s7_eval_q) : v_q[k-1];
        end
      end
      if (ld_out) begin
        out_valid_q <= v_q[NS];
      end
    end
  end

  // Assertions.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q && out_valid_q && out_stall_i))
    else $error("input stalled while the pipeline has room");

  a_result_from_last_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(v_q[NS]))
    else $error("result appeared without a request in the last stage");

  a_lattice_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> (s4_i0_q[0] <= N_TOP && s4_i0_q[1] <= N_TOP && s4_i0_q[2] <= N_TOP))
    else $error("lattice index not reduced below the table size");

  a_hash_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[6] && s6_op_q == pgn3d_pkg::OP_EVAL) |->
      (grad_addr[0] <= N_TOP && grad_addr[7] <= N_TOP))
    else $error("hashed gradient index out of range");

  a_curve_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> (s4_s_q[0] <= pgn3d_pkg::SC_MAX && s4_s_q[0] >= 0))
    else $error("s-curve weight out of range");

endmodule
